// ----- hdl/lgs_pkg.sv -----
// Shared types and constants for the LED grayscale serializer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lgs_pkg;

   localparam int GRAY_BITS                   = 12;
   localparam int INDEX_BITS                  = 11;
   localparam int DEFAULT_DRIVER_COUNT        = 4;
   localparam int DEFAULT_CHANNELS_PER_DRIVER = 24;

   typedef enum logic [1:0] {
      KIND_WRITE_ONE = 2'd0,
      KIND_WRITE_ALL = 2'd1,
      KIND_START     = 2'd2,
      KIND_TICK      = 2'd3
   } lgs_kind_type;

   typedef struct packed {
      lgs_kind_type            kind;
      logic [INDEX_BITS-1:0]   channel_index;
      logic [GRAY_BITS-1:0]    gray_value;
   } lgs_req_type;

   typedef struct packed {
      logic serial_data;
      logic clock_pulse;
      logic latch_pulse;
      logic blank_level;
      logic busy_res;
   } lgs_rsp_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic                    write_one;
      logic                    write_all;
      logic                    shift;
      logic [INDEX_BITS-1:0]   index;
      logic [GRAY_BITS-1:0]    value;
   } lgs_cell_ctl_type;

endpackage

`default_nettype wire

// ----- hdl/lgs_cell.sv -----
// One channel cell: holds a 12-bit level and rotates it through the ring.
// Depends on lgs_pkg.
`default_nettype none

module lgs_cell
   import lgs_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lgs_cell_ctl_type ctl,
   input  wire logic             shift_in,
   output logic                  shift_out
);

   localparam logic [INDEX_BITS-1:0] MyIndex = INDEX_BITS'(CELL_INDEX);

   logic [GRAY_BITS-1:0] level_ff;
   logic [GRAY_BITS-1:0] level_in;

   always_comb begin
      level_in = level_ff;
      if (ctl.write_all || (ctl.write_one && ctl.index == MyIndex)) begin
         level_in = ctl.value;
      end else if (ctl.shift) begin
         // A full pass of the ring restores every level.
         level_in = {level_ff[GRAY_BITS-2:0], shift_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   assign shift_out = level_ff[GRAY_BITS-1];

endmodule

`default_nettype wire

// ----- hdl/lgs_seq.sv -----
// Update sequencer: decodes each word, counts shifted bits, drives latch.
// Depends on lgs_pkg.
`default_nettype none

module lgs_seq
   import lgs_pkg::*;
#(
   parameter int CHANNEL_COUNT = DEFAULT_DRIVER_COUNT * DEFAULT_CHANNELS_PER_DRIVER
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire lgs_req_type       req,
   input  wire logic              top_bit,
   output lgs_cell_ctl_type       ctl,
   output lgs_rsp_type            rsp
);

   localparam int TotalBits  = CHANNEL_COUNT * GRAY_BITS;
   localparam int CountWidth = $clog2(TotalBits);
   localparam logic [CountWidth-1:0] LastBit = CountWidth'(TotalBits - 1);

   logic [CountWidth-1:0] count_ff, count_in;
   logic                  shifting_ff, shifting_in;
   logic                  latch_ff, latch_in;
   logic                  busy;

   assign busy = shifting_ff || latch_ff;

   always_comb begin
      count_in      = count_ff;
      shifting_in   = shifting_ff;
      latch_in      = latch_ff;
      ctl.write_one = 1'b0;
      ctl.write_all = 1'b0;
      ctl.shift     = 1'b0;
      ctl.index     = req.channel_index;
      ctl.value     = req.gray_value;
      rsp           = '0;
      if (accept) begin
         unique case (req.kind)
            KIND_WRITE_ONE: begin
               rsp.busy_res  = busy;
               ctl.write_one = !busy;
            end
            KIND_WRITE_ALL: begin
               rsp.busy_res  = busy;
               ctl.write_all = !busy;
            end
            KIND_START: begin
               rsp.busy_res = 1'b1;
               if (!busy) begin
                  shifting_in = 1'b1;
                  count_in    = '0;
               end
            end
            KIND_TICK: begin
               if (shifting_ff) begin
                  rsp.serial_data = top_bit;
                  rsp.clock_pulse = 1'b1;
                  rsp.busy_res    = 1'b1;
                  ctl.shift       = 1'b1;
                  if (count_ff == LastBit) begin
                     count_in    = '0;
                     shifting_in = 1'b0;
                     latch_in    = 1'b1;
                  end else begin
                     count_in = count_ff + CountWidth'(1);
                  end
               end else if (latch_ff) begin
                  rsp.latch_pulse = 1'b1;
                  rsp.blank_level = 1'b1;
                  rsp.busy_res    = 1'b1;
                  latch_in        = 1'b0;
                  count_in        = '0;
               end
            end
            default: begin
               rsp = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         shifting_ff <= 1'b0;
         latch_ff    <= 1'b0;
      end else begin
         count_ff    <= count_in;
         shifting_ff <= shifting_in;
         latch_ff    <= latch_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/led_grayscale_serializer_top.sv -----
// LED grayscale serializer: a ring of channel cells plus the update sequencer.
// Each result word is registered, valid in the cycle after its word is accepted.
// Throughput one word per cycle while the receiver drains the single output register.
// A full update takes one start word, channels*12 shifting ticks and one latch tick.
// Reset (synchronous) clears all levels, the bit counter and the busy flags.
`default_nettype none

module led_grayscale_serializer_top
   import lgs_pkg::*;
#(
   parameter int DRIVER_COUNT        = DEFAULT_DRIVER_COUNT,
   parameter int CHANNELS_PER_DRIVER = DEFAULT_CHANNELS_PER_DRIVER
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire lgs_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output lgs_rsp_type      rsp_data
);

   localparam int ChannelCount = DRIVER_COUNT * CHANNELS_PER_DRIVER;

   logic             accept;
   lgs_cell_ctl_type ctl;
   lgs_rsp_type      rsp_next;
   logic [ChannelCount-1:0] msb;

   logic        rsp_valid_ff, rsp_valid_in;
   lgs_rsp_type rsp_data_ff, rsp_data_in;

   // Take a new word whenever the output slot is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   lgs_seq #(
      .CHANNEL_COUNT(ChannelCount)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .top_bit(msb[ChannelCount-1]),
      .ctl    (ctl),
      .rsp    (rsp_next)
   );

   for (genvar i = 0; i < ChannelCount; i++) begin : g_cell
      lgs_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .shift_in (msb[(i + ChannelCount - 1) % ChannelCount]),
         .shift_out(msb[i])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- dv/tb_led_grayscale_serializer_top.sv -----
// Testbench for led_grayscale_serializer_top: directed words from a table, then random
// write/start/tick traffic, results checked against table goldens or an in-bench model.
// Depends on lgs_pkg and the top-level RTL only.
`default_nettype none

module tb_led_grayscale_serializer_top;
   import lgs_pkg::*;

   localparam int CHANNELS      = DEFAULT_DRIVER_COUNT * DEFAULT_CHANNELS_PER_DRIVER;
   localparam int FRAME_BITS    = CHANNELS * GRAY_BITS;
   localparam int RANDOM_WORDS  = 1500;
   localparam int PHASE_WORDS   = 150;
   localparam int HOLD_OFF_AT   = 600;
   localparam int HOLD_OFF_LEN  = 300;
   localparam int DRAIN_CYCLES  = 20;
   localparam int MAX_REPORTS   = 10;
   localparam int LIMIT_CYCLES  = 200000;

   localparam lgs_rsp_type RSP_QUIET = '0;
   localparam lgs_rsp_type RSP_BUSY  = '{serial_data: 1'b0, clock_pulse: 1'b0,
                                         latch_pulse: 1'b0, blank_level: 1'b0,
                                         busy_res: 1'b1};

   typedef struct {
      lgs_req_type word;
      bit          has_golden;
      lgs_rsp_type golden;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   lgs_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   lgs_rsp_type rsp_data;

   // serializer model state
   logic [GRAY_BITS-1:0] gray_levels [CHANNELS];
   int unsigned          bits_shifted;
   bit                   shift_active;
   bit                   latch_due;

   lgs_rsp_type pending_rsp_q[$];
   int          words_sent;
   int          error_count;
   int          cycle_count;
   bit          held_off;

   led_grayscale_serializer_top #(
      .DRIVER_COUNT        (DEFAULT_DRIVER_COUNT),
      .CHANNELS_PER_DRIVER (DEFAULT_CHANNELS_PER_DRIVER)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic bit update_running();
      return shift_active || latch_due;
   endfunction

   function automatic lgs_rsp_type serialize_step(lgs_req_type w);
      lgs_rsp_type r;
      int          ch;
      int          b;
      r = '0;
      case (w.kind)
         KIND_WRITE_ONE: begin
            if (update_running()) r.busy_res = 1'b1;
            else if (w.channel_index < CHANNELS) gray_levels[w.channel_index] = w.gray_value;
         end
         KIND_WRITE_ALL: begin
            if (update_running()) r.busy_res = 1'b1;
            else foreach (gray_levels[i]) gray_levels[i] = w.gray_value;
         end
         KIND_START: begin
            if (!update_running()) begin
               shift_active = 1'b1;
               bits_shifted = 0;
            end
            r.busy_res = 1'b1;
         end
         default: begin
            if (shift_active) begin
               // highest channel first, MSB first
               ch = CHANNELS - 1 - int'(bits_shifted / GRAY_BITS);
               b  = GRAY_BITS - 1 - int'(bits_shifted % GRAY_BITS);
               r.serial_data = gray_levels[ch][b];
               r.clock_pulse = 1'b1;
               r.busy_res    = 1'b1;
               bits_shifted++;
               if (bits_shifted >= FRAME_BITS) begin
                  shift_active = 1'b0;
                  latch_due    = 1'b1;
               end
            end else if (latch_due) begin
               r.latch_pulse = 1'b1;
               r.blank_level = 1'b1;
               r.busy_res    = 1'b1;
               latch_due     = 1'b0;
               bits_shifted  = 0;
            end
         end
      endcase
      return r;
   endfunction

   function automatic stim_row_type row(lgs_kind_type k, int idx, int val,
                                        bit has_golden = 1'b0, lgs_rsp_type golden = '0);
      stim_row_type s;
      s.word.kind          = k;
      s.word.channel_index = idx[INDEX_BITS-1:0];
      s.word.gray_value    = val[GRAY_BITS-1:0];
      s.has_golden         = has_golden;
      s.golden             = golden;
      return s;
   endfunction

   function automatic lgs_req_type next_random_word();
      lgs_req_type w;
      int          pick;
      w.channel_index = INDEX_BITS'($urandom_range(0, 2047));
      w.gray_value    = GRAY_BITS'($urandom_range(0, 4095));
      pick = $urandom_range(0, 99);
      if (update_running()) begin
         // mostly ticks; sprinkle writes and starts that must be dropped
         if (pick < 94) w.kind = KIND_TICK;
         else w.kind = lgs_kind_type'($urandom_range(0, 2));
      end else if (pick < 6) begin
         w.kind = KIND_TICK;
      end else if (pick < 12) begin
         w.kind = KIND_WRITE_ALL;
         if ($urandom_range(0, 1) == 0) w.gray_value = '0;
      end else if (pick < 40) begin
         w.kind = KIND_START;
      end else begin
         w.kind = KIND_WRITE_ONE;
         if ($urandom_range(0, 99) < 85)
            w.channel_index = INDEX_BITS'($urandom_range(0, CHANNELS - 1));
         if ($urandom_range(0, 9) == 0)
            w.gray_value = ($urandom_range(0, 1) == 0) ? '0 : '1;
      end
      return w;
   endfunction

   function automatic int idle_phase();
      return (words_sent / PHASE_WORDS) % 4;
   endfunction

   function automatic int sender_idle_pct();
      case (idle_phase())
         1: return 48;
         3: return 28;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case (idle_phase())
         2: return 48;
         3: return 28;
         default: return 0;
      endcase
   endfunction

   // Called at a falling edge; returns at a falling edge after the word is taken.
   task automatic send_word(lgs_req_type w, bit has_golden, lgs_rsp_type golden);
      lgs_rsp_type predicted;
      while ($urandom_range(0, 99) < sender_idle_pct()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = serialize_step(w);
      pending_rsp_q.push_back(has_golden ? golden : predicted);
      words_sent++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      lgs_rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            if (error_count < MAX_REPORTS)
               $display("ERROR: unexpected result word %b", rsp_data);
            error_count++;
         end else begin
            exp_rsp = pending_rsp_q.pop_front();
            if (rsp_data.serial_data !== exp_rsp.serial_data ||
                rsp_data.clock_pulse !== exp_rsp.clock_pulse ||
                rsp_data.latch_pulse !== exp_rsp.latch_pulse ||
                rsp_data.blank_level !== exp_rsp.blank_level ||
                rsp_data.busy_res    !== exp_rsp.busy_res) begin
               if (error_count < MAX_REPORTS)
                  $display("ERROR: data/clk/latch/blank/busy exp %b %b %b %b %b got %b %b %b %b %b",
                           exp_rsp.serial_data, exp_rsp.clock_pulse, exp_rsp.latch_pulse,
                           exp_rsp.blank_level, exp_rsp.busy_res,
                           rsp_data.serial_data, rsp_data.clock_pulse, rsp_data.latch_pulse,
                           rsp_data.blank_level, rsp_data.busy_res);
               error_count++;
            end
         end
      end
   end

   // result receiver, with one long hold-off to back the block up
   initial begin
      rsp_ready = 1'b0;
      held_off  = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held_off && words_sent >= HOLD_OFF_AT) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_LEN) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) < receiver_stall_pct()) ? 1'b0 : 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin
      stim_row_type directed_rows[$];
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      words_sent   = 0;
      error_count  = 0;
      cycle_count  = 0;
      bits_shifted = 0;
      shift_active = 1'b0;
      latch_due    = 1'b0;
      foreach (gray_levels[i]) gray_levels[i] = '0;

      directed_rows.push_back(row(KIND_TICK,      0,            0,      1'b1, RSP_QUIET));
      directed_rows.push_back(row(KIND_WRITE_ALL, 0,            12'hFFF, 1'b1, RSP_QUIET));
      directed_rows.push_back(row(KIND_WRITE_ALL, 2047,         0,      1'b1, RSP_QUIET));
      directed_rows.push_back(row(KIND_WRITE_ONE, CHANNELS - 1, 12'h800, 1'b1, RSP_QUIET));
      directed_rows.push_back(row(KIND_WRITE_ONE, CHANNELS - 2, 12'hFFF, 1'b1, RSP_QUIET));
      directed_rows.push_back(row(KIND_WRITE_ONE, 0,            12'h001, 1'b1, RSP_QUIET));
      directed_rows.push_back(row(KIND_WRITE_ONE, CHANNELS,     12'hFFF, 1'b1, RSP_QUIET));
      directed_rows.push_back(row(KIND_WRITE_ONE, 2047,         12'hABC, 1'b1, RSP_QUIET));
      directed_rows.push_back(row(KIND_START,     0,            0,      1'b1, RSP_BUSY));
      directed_rows.push_back(row(KIND_START,     2047,         12'hFFF, 1'b1, RSP_BUSY));
      directed_rows.push_back(row(KIND_WRITE_ONE, CHANNELS - 1, 12'h000, 1'b1, RSP_BUSY));
      directed_rows.push_back(row(KIND_WRITE_ALL, 0,            12'h000, 1'b1, RSP_BUSY));
      repeat (14) directed_rows.push_back(row(KIND_TICK, 2047, 12'hFFF));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].has_golden, directed_rows[i].golden);
      while (words_sent < directed_rows.size() + RANDOM_WORDS)
         send_word(next_random_word(), 1'b0, RSP_QUIET);
      req_valid <= 1'b0;

      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
